/* sv/rhc_pkg.sv */
`timescale 1ns / 1ps

package rhc_pkg;

  // Input selector codes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_COMP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DANS_OFFSET = 2'd0;
  localparam logic [1:0] REG_XOR_KEY     = 2'd1;

  // Classified request kinds handed from front to back
  localparam logic [1:0] KIND_HOLD = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  // Byte window that never contributes (PE header pointer field)
  localparam logic [15:0] SKIP_LO   = 16'h003C;
  localparam logic [15:0] SKIP_HI   = 16'h0040;
  localparam logic [15:0] INDEX_MAX = 16'hFFFF;
  localparam int unsigned HALF_BITS = 16;

  localparam logic [15:0] DANS_RESET = 16'd128;
  localparam logic [31:0] KEY_RESET  = 32'd0;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  // Front to back request
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } item_t;

  // Result entry
  typedef struct packed {
    logic [31:0] checksum;
    logic        counted;
  } result_t;

  // Rotate left by 0..31; a zero amount is the identity
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} << s;
    return d[63:32];
  endfunction

endpackage

/* sv/rhc_fifo.sv */
`timescale 1ns / 1ps

module rhc_fifo #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/rhc_front.sv */
`timescale 1ns / 1ps

module rhc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          op,
  input  logic [7:0]          byte_value,
  input  logic [63:0]         comp_entry,
  input  logic [15:0]         dans_offset,
  input  logic [31:0]         xor_key,
  output rhc_pkg::item_t      item,
  output logic [15:0]         byte_index
);

  logic [63:0] decoded;
  logic [31:0] comp_term;
  logic [31:0] byte_term;
  logic        in_skip;
  logic        byte_counts;

  // Comp id: unmask, then rotate {product, build} by count
  assign decoded   = comp_entry ^ {xor_key, xor_key};
  assign comp_term = rhc_pkg::rotl32(decoded[31:0], decoded[36:32]);

  // File byte: rotate by index, skip the header pointer field
  assign byte_term   = rhc_pkg::rotl32({24'd0, byte_value}, byte_index[4:0]);
  assign in_skip     = (byte_index >= rhc_pkg::SKIP_LO) && (byte_index < rhc_pkg::SKIP_HI);
  assign byte_counts = (byte_index < dans_offset) && !in_skip;

  // Classify the request
  always_comb begin
    item.kind  = rhc_pkg::KIND_HOLD;
    item.value = byte_term;
    case (op)
      rhc_pkg::OP_BYTE: begin
        item.kind = byte_counts ? rhc_pkg::KIND_ADD : rhc_pkg::KIND_HOLD;
      end
      rhc_pkg::OP_COMP: begin
        item.kind  = rhc_pkg::KIND_ADD;
        item.value = comp_term;
      end
      rhc_pkg::OP_RESTART: begin
        item.kind  = rhc_pkg::KIND_LOAD;
        item.value = {16'd0, dans_offset};
      end
      default: begin
        item.kind = rhc_pkg::KIND_HOLD;
      end
    endcase
  end

  // Byte position, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (accept) begin
      if (op == rhc_pkg::OP_RESTART) begin
        byte_index <= '0;
      end else if (op == rhc_pkg::OP_BYTE && byte_index != rhc_pkg::INDEX_MAX) begin
        byte_index <= byte_index + 16'd1;
      end
    end
  end

endmodule

/* sv/rhc_back.sv */
`timescale 1ns / 1ps

module rhc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  rhc_pkg::item_t   item,
  output logic             take,
  input  logic             res_full,
  output rhc_pkg::result_t res,
  output logic [31:0]      sum
);

  logic [31:0] sum_next;

  assign take = item_valid && !res_full;

  // Accumulate
  always_comb begin
    case (item.kind)
      rhc_pkg::KIND_ADD:  sum_next = sum + item.value;
      rhc_pkg::KIND_LOAD: sum_next = item.value;
      default:            sum_next = sum;
    endcase
  end

  assign res.checksum = sum_next;
  assign res.counted  = (item.kind == rhc_pkg::KIND_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (take) begin
      sum <= sum_next;
    end
  end

endmodule

/* sv/rich_header_checksum.sv */
`timescale 1ns / 1ps

// Streaming PE Rich header checksum.
// Input queue side: drive op/byte_value/comp_entry with push; a request is
// taken when push is high and full is low. Op 0 is a file byte (in order
// from offset 0), op 1 a raw comp id entry, op 2 restarts the sum at
// dans_offset. Every request yields exactly one result.
// Result queue side: while empty is low, checksum/counted show the oldest
// result; pop with empty low takes it.
// Config: cfg_valid/cfg_ready with cfg_index (0 dans_offset, 1 xor_key) and
// cfg_data; cfg_ready is always high. Write only while the block is idle.
// Throughput: one request per cycle while full stays low. A result shows on
// the result ports after its request has passed the request queue and the
// back end has written it into the result queue, and can then be popped
// (front classify into a small request queue, then the accumulator writes
// the result queue). The single 32-bit add in the back end sets the rate.
// Reset: sum and byte position clear, dans_offset = 128, xor_key = 0, both
// queues empty. When pop is held low the result queue fills, the back end
// stops, the request queue fills and full rises; nothing is dropped.
module rich_header_checksum #(
  parameter int unsigned MID_DEPTH = rhc_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = rhc_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [7:0]  byte_value,
  input  logic [63:0] comp_entry,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] checksum,
  output logic        counted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned ITEM_W = $bits(rhc_pkg::item_t);
  localparam int unsigned RES_W  = $bits(rhc_pkg::result_t);

  logic [15:0]      dans_offset;
  logic [31:0]      xor_key;
  logic             accept;
  rhc_pkg::item_t   front_item;
  rhc_pkg::item_t   back_item;
  logic [ITEM_W-1:0] back_item_bits;
  logic [15:0]      byte_index;
  logic             mid_empty;
  logic             take;
  logic             res_full;
  rhc_pkg::result_t res;
  logic [RES_W-1:0] out_bits;
  rhc_pkg::result_t out_res;
  logic [31:0]      sum;

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dans_offset <= rhc_pkg::DANS_RESET;
      xor_key     <= rhc_pkg::KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rhc_pkg::REG_DANS_OFFSET) begin
        dans_offset <= cfg_data[15:0];
      end else if (cfg_index == rhc_pkg::REG_XOR_KEY) begin
        xor_key <= cfg_data;
      end
    end
  end

  rhc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (op),
    .byte_value  (byte_value),
    .comp_entry  (comp_entry),
    .dans_offset (dans_offset),
    .xor_key     (xor_key),
    .item        (front_item),
    .byte_index  (byte_index)
  );

  // Request queue between front and back
  rhc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (full),
    .pop   (take),
    .dout  (back_item_bits),
    .empty (mid_empty)
  );

  assign back_item = rhc_pkg::item_t'(back_item_bits);

  rhc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty),
    .item       (back_item),
    .take       (take),
    .res_full   (res_full),
    .res        (res),
    .sum        (sum)
  );

  // Result queue
  rhc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_bits),
    .empty (empty)
  );

  assign out_res  = rhc_pkg::result_t'(out_bits);
  assign checksum = out_res.checksum;
  assign counted  = out_res.counted;

  // Restart request clears the byte position
  a_restart_clears_index: assert property (@(posedge clk) disable iff (rst)
    accept && op == rhc_pkg::OP_RESTART |=> byte_index == 16'd0)
    else $error("byte position not cleared by restart");

  // A load in the back end sets the sum to the carried offset
  a_load_sets_sum: assert property (@(posedge clk) disable iff (rst)
    take && back_item.kind == rhc_pkg::KIND_LOAD |=> sum == $past(back_item.value))
    else $error("sum not loaded on restart");

  // Back end only runs with work queued and room for the result
  a_take_guarded: assert property (@(posedge clk) disable iff (rst)
    take |-> !mid_empty && !res_full)
    else $error("back end took a request without room");

endmodule

/* tb/rich_header_checksum_tb.sv */
`timescale 1ns / 1ps

module rich_header_checksum_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int LONG_RUN = 150;
  localparam int RAND_PER_PHASE = 100;
  localparam int NUM_PHASES = 6;
  localparam int NUM_ROWS = 18;
  localparam int MAX_PRINTS = 40;

  // One row of the directed table; reps > 1 repeats the request
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  bv;
    logic [63:0] ce;
    logic [7:0]  reps;
    logic        rnd;
    logic        fixed;
    logic [31:0] sum;
    logic        cnt;
  } row_t;

  // Directed requests under the reset settings (offset 128, key 0)
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{OP_UNUSED, 8'h00, 64'h0, 8'd1, 1'b0, 1'b1, 32'd0, 1'b0},
    '{rhc_pkg::OP_BYTE, 8'hFF, 64'h0, 8'd1, 1'b0, 1'b1, 32'hFF, 1'b1},
    '{rhc_pkg::OP_RESTART, 8'h00, 64'h0, 8'd1, 1'b0, 1'b1, 32'd128, 1'b0},
    '{rhc_pkg::OP_BYTE, 8'h00, 64'h0, 8'd1, 1'b0, 1'b1, 32'd128, 1'b1},
    '{rhc_pkg::OP_BYTE, 8'h80, 64'h0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_BYTE, 8'hFF, 64'h0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_COMP, 8'h00, 64'h0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_COMP, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_COMP, 8'h00, 64'h0000_0020_1234_5678, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_COMP, 8'h00, 64'h0000_001F_8000_0001, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{OP_UNUSED, 8'h00, 64'h0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_RESTART, 8'h00, 64'h0, 8'd1, 1'b0, 1'b1, 32'd128, 1'b0},
    '{rhc_pkg::OP_BYTE, 8'h00, 64'h0, 8'd60, 1'b1, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_BYTE, 8'hFF, 64'h0, 8'd4, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_BYTE, 8'h00, 64'h0, 8'd64, 1'b1, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_BYTE, 8'hFF, 64'h0, 8'd8, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_COMP, 8'h00, 64'hDEAD_BEEF_0123_4567, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{rhc_pkg::OP_RESTART, 8'h00, 64'h0, 8'd1, 1'b0, 1'b1, 32'd128, 1'b0}
  };

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  op;
  logic [7:0]  byte_value;
  logic [63:0] comp_entry;
  logic        empty;
  logic        pop;
  logic [31:0] checksum;
  logic        counted;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Predictor state and settings
  logic [31:0] sum_q;
  logic [15:0] pos_q;
  logic [15:0] dans_q;
  logic [31:0] key_q;

  rhc_pkg::result_t pending_sums[$];
  rhc_pkg::result_t want;
  int      errors;
  int      cycle_count;
  int      burst_left;

  rich_header_checksum DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .byte_value (byte_value),
    .comp_entry (comp_entry),
    .empty      (empty),
    .pop        (pop),
    .checksum   (checksum),
    .counted    (counted),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] v, input logic [4:0] n);
    if (n == 5'd0) return v;
    return (v << n) | (v >> (32 - int'(n)));
  endfunction

  // Update the running checksum for one accepted request; returns its result
  function automatic rhc_pkg::result_t advance_checksum(input logic [1:0] o,
                                                        input logic [7:0] b,
                                                        input logic [63:0] e);
    rhc_pkg::result_t res;
    logic [63:0]      x;
    res.counted = 1'b0;
    case (o)
      rhc_pkg::OP_BYTE: begin
        if (pos_q < dans_q && !(pos_q >= rhc_pkg::SKIP_LO && pos_q < rhc_pkg::SKIP_HI)) begin
          sum_q = sum_q + rot_left({24'd0, b}, pos_q[4:0]);
          res.counted = 1'b1;
        end
        if (pos_q != rhc_pkg::INDEX_MAX) pos_q = pos_q + 16'd1;
      end
      rhc_pkg::OP_COMP: begin
        // key replicated to 64 bits; term is {product, build}, rotate by count
        x = e ^ {key_q, key_q};
        sum_q = sum_q + rot_left(x[31:0], x[36:32]);
        res.counted = 1'b1;
      end
      rhc_pkg::OP_RESTART: begin
        sum_q = {16'd0, dans_q};
        pos_q = 16'd0;
      end
      default: ;
    endcase
    res.checksum = sum_q;
    return res;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random entry; sometimes lands the rotate amount on zero after the XOR
  function automatic logic [63:0] pick_entry();
    logic [63:0] e;
    e = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) e[36:32] = key_q[4:0];
    return e;
  endfunction

  // Present one request, wait for it to be taken, record the expected result
  task automatic send_request(input logic [1:0] o, input logic [7:0] b, input logic [63:0] e,
                              input logic fixed, input rhc_pkg::result_t fixed_res);
    rhc_pkg::result_t res;
    int               gap;
    @(negedge clk);
    push       <= 1'b1;
    op         <= o;
    byte_value <= b;
    comp_entry <= e;
    do @(posedge clk); while (full);
    res = advance_checksum(o, b, e);
    pending_sums.push_back(fixed ? fixed_res : res);
    // burst bookkeeping: idle for a random gap between bursts
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and wait until every expected result has been popped
  task automatic drain_results(input int tail);
    @(negedge clk);
    push <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rhc_pkg::REG_DANS_OFFSET) dans_q = data[15:0];
    else if (idx == rhc_pkg::REG_XOR_KEY) key_q = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly restart + byte run + comp ids; the rest stray requests and noise
  task automatic run_random(input int target);
    int sent;
    int len;
    int lim;
    int r;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_request(rhc_pkg::OP_RESTART, pick_byte(), pick_entry(), 1'b0, '0);
        lim = int'(dans_q) + 10 > 160 ? 160 : int'(dans_q) + 10;
        len = $urandom_range(0, lim);
        repeat (len) send_request(rhc_pkg::OP_BYTE, pick_byte(), pick_entry(), 1'b0, '0);
        r = $urandom_range(0, 4);
        repeat (r) send_request(rhc_pkg::OP_COMP, pick_byte(), pick_entry(), 1'b0, '0);
        sent += 1 + len + r;
      end else if (r == 7) begin
        send_request(OP_UNUSED, pick_byte(), pick_entry(), 1'b0, '0);
      end else if (r == 8) begin
        send_request(rhc_pkg::OP_COMP, pick_byte(), pick_entry(), 1'b0, '0);
        sent++;
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) send_request(rhc_pkg::OP_BYTE, pick_byte(), pick_entry(), 1'b0, '0);
        sent += len;
      end
    end
  endtask

  // Result side: stall pattern in stretches of changing character
  initial begin
    int mode;
    int dur;
    pop = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      dur = $urandom_range(5, 40);
      repeat (dur) begin
        @(negedge clk);
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom);
          2: pop <= $urandom_range(0, 11) == 0;
          default: pop <= ~pop;
        endcase
      end
    end
  end

  // Compare every popped result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_sums.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: unexpected result checksum=%h counted=%b", $time, checksum, counted);
      end else begin
        want = pending_sums.pop_front();
        if (checksum !== want.checksum) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: checksum expected %h got %h", $time, want.checksum, checksum);
        end
        if (counted !== want.counted) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: counted expected %b got %b", $time, want.counted, counted);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main sequence
  initial begin
    row_t        row;
    logic [7:0]  bv;
    logic [15:0] dans_set [NUM_PHASES];
    logic [31:0] key_set  [NUM_PHASES];
    errors      = 0;
    cycle_count = 0;
    burst_left  = 0;
    rst         = 1'b1;
    push        = 1'b0;
    op          = rhc_pkg::OP_BYTE;
    byte_value  = 8'd0;
    comp_entry  = 64'd0;
    cfg_valid   = 1'b0;
    cfg_index   = rhc_pkg::REG_DANS_OFFSET;
    cfg_data    = 32'd0;
    sum_q       = 32'd0;
    pos_q       = 16'd0;
    dans_q      = rhc_pkg::DANS_RESET;
    key_q       = rhc_pkg::KEY_RESET;

    dans_set = '{16'hFFFF, 16'd0, 16'd62, 16'd64, 16'($urandom_range(1, 300)), 16'd128};
    key_set  = '{32'hFFFF_FFFF, 32'd0, $urandom, $urandom, $urandom, 32'h8000_0001};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset settings
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIR_ROWS[i];
      for (int k = 0; k < int'(row.reps); k++) begin
        bv = row.rnd ? pick_byte() : row.bv;
        send_request(row.op, bv, row.ce, row.fixed && row.reps == 8'd1, {row.sum, row.cnt});
      end
    end

    // Phases over several register settings, the extremes among them
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results(4);
      write_reg(rhc_pkg::REG_DANS_OFFSET, {16'($urandom), dans_set[p]});
      write_reg(rhc_pkg::REG_XOR_KEY, key_set[p]);
      if (p == 0) begin
        // long file under the widest offset: rotate amounts wrap past 31
        send_request(rhc_pkg::OP_RESTART, 8'h00, 64'h0, 1'b0, '0);
        repeat (LONG_RUN) send_request(rhc_pkg::OP_BYTE, pick_byte(), 64'h0, 1'b0, '0);
        send_request(rhc_pkg::OP_COMP, 8'h00, pick_entry(), 1'b0, '0);
      end
      if (p == 2) begin
        run_random(RAND_PER_PHASE / 2);
        drain_results(0);
        run_random(RAND_PER_PHASE / 2);
      end else begin
        run_random(RAND_PER_PHASE);
      end
    end

    drain_results(10);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
